// File: design/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, register map, reset values and types of the counting
// background subtractor.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int IDX_W = 19;
  localparam int PIX_W = 8;
  localparam int MIN_W = 16;
  localparam int MAX_W = 16;
  localparam int CT_W  = 7;
  localparam int HT_W  = 8;

  localparam int PIXEL_COUNT_DEF = 524288;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic             HISTORY_MODE_RST = 1'b1;
  localparam logic [MIN_W-1:0] MIN_STAB_RST     = 16'd15;
  localparam logic [MAX_W-1:0] MAX_STAB_RST     = 16'd900;
  localparam logic [CT_W-1:0]  CHANGE_THR_RST   = 7'd5;
  localparam logic [HT_W-1:0]  HIST_THR_RST     = 8'd30;

  typedef enum logic [2:0] {
    REG_HISTORY_MODE = 3'd0,
    REG_MIN_STAB     = 3'd1,
    REG_MAX_STAB     = 3'd2,
    REG_CHANGE_THR   = 3'd3,
    REG_HIST_THR     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             history_mode;
    logic [MIN_W-1:0] min_stability;
    logic [MAX_W-1:0] max_stability;
    logic [CT_W-1:0]  change_threshold;
    logic [HT_W-1:0]  history_threshold;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_value;
    logic             init_frame;
  } pix_item_t;

endpackage

// File: design/cbs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_in_if / cbs_out_if
// Valid/ready channels for pixel items and for per-pixel results.
// ----------------------------------------------------------------------------
interface cbs_in_if;
  import cbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [PIX_W-1:0] pixel_value;
  logic             init_frame;

  modport source (output valid, output pixel_index, output pixel_value,
                  output init_frame, input ready);
  modport sink (input valid, input pixel_index, input pixel_value,
                input init_frame, output ready);
endinterface

interface cbs_out_if;
  import cbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;
  logic             foreground;
  logic [PIX_W-1:0] background_value;

  modport source (output valid, output out_index, output foreground,
                  output background_value, input ready);
  modport sink (input valid, input out_index, input foreground,
                input background_value, output ready);
endinterface

// File: design/cbs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_cfg
// APB-style register file holding the subtractor settings.
// ----------------------------------------------------------------------------
module cbs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cbs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output cbs_pkg::cfg_t                    cfg
);
  import cbs_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.history_mode      <= HISTORY_MODE_RST;
      cfg_r.min_stability     <= MIN_STAB_RST;
      cfg_r.max_stability     <= MAX_STAB_RST;
      cfg_r.change_threshold  <= CHANGE_THR_RST;
      cfg_r.history_threshold <= HIST_THR_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_HISTORY_MODE: cfg_r.history_mode      <= pwdata[0];
        REG_MIN_STAB:     cfg_r.min_stability     <= pwdata[MIN_W-1:0];
        REG_MAX_STAB:     cfg_r.max_stability     <= pwdata[MAX_W-1:0];
        REG_CHANGE_THR:   cfg_r.change_threshold  <= pwdata[CT_W-1:0];
        REG_HIST_THR:     cfg_r.history_threshold <= pwdata[HT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HISTORY_MODE: prdata = CFG_DATA_W'(cfg_r.history_mode);
      REG_MIN_STAB:     prdata = CFG_DATA_W'(cfg_r.min_stability);
      REG_MAX_STAB:     prdata = CFG_DATA_W'(cfg_r.max_stability);
      REG_CHANGE_THR:   prdata = CFG_DATA_W'(cfg_r.change_threshold);
      REG_HIST_THR:     prdata = CFG_DATA_W'(cfg_r.history_threshold);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: design/cbs_addr_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_addr_map
// Two-stage front end: folds the pixel index into the state memory range
// (quotient by shift, reciprocal multiply or zero; remainder, one correction).
// ----------------------------------------------------------------------------
module cbs_addr_map #(
  parameter int PIXEL_COUNT = cbs_pkg::PIXEL_COUNT_DEF,
  parameter int ADDR_W      = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  cbs_pkg::pix_item_t    in_item,
  output logic                  out_v,
  output cbs_pkg::pix_item_t    out_item,
  output logic [ADDR_W-1:0]     out_addr
);
  import cbs_pkg::*;

  localparam int              Q_W   = IDX_W + 1;
  localparam longint unsigned PC    = longint'(PIXEL_COUNT);
  localparam int              LOG2P = $clog2(PIXEL_COUNT);
  localparam longint unsigned SPAN  = 64'd1 << IDX_W;

  logic [Q_W-1:0]    q_nxt;
  logic              a_v_r;
  pix_item_t         a_item_r;
  logic [Q_W-1:0]    a_q_r;
  logic              b_v_r;
  pix_item_t         b_item_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic [IDX_W:0]    qp;
  logic [IDX_W:0]    rem_raw;
  logic [IDX_W:0]    rem;

  generate
    if (PC >= SPAN) begin : g_wide
      assign q_nxt = '0;
    end else if ((PC & (PC - 64'd1)) == 64'd0) begin : g_pow2
      assign q_nxt = Q_W'(in_item.pixel_index >> LOG2P);
    end else begin : g_recip
      localparam int              SH      = IDX_W + LOG2P;
      localparam int              RECIP_W = IDX_W + 2;
      localparam int              PROD_W  = IDX_W + RECIP_W;
      localparam longint unsigned RECIP   = ((64'd1 << SH) + PC - 64'd1) / PC;
      logic [PROD_W-1:0] prod;
      assign prod  = PROD_W'(in_item.pixel_index) * PROD_W'(RECIP);
      assign q_nxt = Q_W'(prod >> SH);
    end
  endgenerate

  assign qp      = (IDX_W + 1)'(a_q_r * (IDX_W + 1)'(PC));
  assign rem_raw = {1'b0, a_item_r.pixel_index} - qp;
  assign rem     = (64'(rem_raw) >= PC) ? rem_raw - (IDX_W + 1)'(PC) : rem_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= in_item;
      a_q_r    <= q_nxt;
      b_item_r <= a_item_r;
      b_addr_r <= ADDR_W'(rem);
    end
  end

  assign out_v    = b_v_r;
  assign out_item = b_item_r;
  assign out_addr = b_addr_r;

endmodule

// File: design/cbs_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_state_mem
// Per-pixel state store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbs_state_mem #(
  parameter int DEPTH  = cbs_pkg::PIXEL_COUNT_DEF,
  parameter int ADDR_W = 19,
  parameter int DATA_W = 56
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cbs_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_update
// Per-pixel state update: simple stability rule or history rule.
// ----------------------------------------------------------------------------
module cbs_update #(
  parameter int CB = cbs_pkg::COUNT_BITS_DEF
) (
  input  cbs_pkg::cfg_t                  cfg,
  input  logic [cbs_pkg::PIX_W-1:0]      pix,
  input  logic [cbs_pkg::PIX_W-1:0]      prev,
  input  logic [CB-1:0]                  stab,
  input  logic [cbs_pkg::PIX_W-1:0]      hcol,
  input  logic [CB-1:0]                  hstab,
  input  logic [cbs_pkg::PIX_W-1:0]      bg,
  output logic [CB-1:0]                  n_stab,
  output logic [cbs_pkg::PIX_W-1:0]      n_hcol,
  output logic [CB-1:0]                  n_hstab,
  output logic [cbs_pkg::PIX_W-1:0]      n_bg,
  output logic                           fg
);
  import cbs_pkg::*;

  localparam int CMP_W = ((CB > MIN_W) ? CB : MIN_W) + 1;

  logic [PIX_W:0] d_prev;
  logic [PIX_W:0] d_hist;
  logic [PIX_W:0] ct3;
  logic [CB-1:0]  s_simple;

  function automatic logic [CB-1:0] cnt_up(input logic [CB-1:0] c,
                                           input logic [MAX_W-1:0] lim);
    logic [CB-1:0] r;
    r = c;
    if ((CMP_W'(c) < CMP_W'(lim)) && (c != '1)) begin
      r = c + CB'(1);
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] cnt_down(input logic [CB-1:0] c);
    return (c != '0) ? c - CB'(1) : c;
  endfunction

  assign d_prev   = (pix > prev) ? (PIX_W + 1)'(pix - prev) : (PIX_W + 1)'(prev - pix);
  assign d_hist   = (pix > hcol) ? (PIX_W + 1)'(pix - hcol) : (PIX_W + 1)'(hcol - pix);
  assign ct3      = (PIX_W + 1)'(cfg.change_threshold) + {1'b0, cfg.change_threshold, 1'b0};
  assign s_simple = (stab != '1) ? stab + CB'(1) : stab;

  always_comb begin
    n_stab  = stab;
    n_hcol  = hcol;
    n_hstab = hstab;
    n_bg    = bg;
    fg      = 1'b1;
    if (!cfg.history_mode) begin
      if (d_prev < ct3) begin
        if (CMP_W'(s_simple) == CMP_W'(cfg.min_stability)) begin
          n_stab = s_simple - CB'(1);
          n_bg   = prev;
          fg     = 1'b0;
        end else begin
          n_stab = s_simple;
        end
      end else begin
        n_stab = '0;
      end
    end else if (d_hist < (PIX_W + 1)'(cfg.history_threshold)) begin
      n_stab  = '0;
      n_hstab = cnt_up(hstab, cfg.max_stability);
      if (CMP_W'(n_hstab) > CMP_W'(cfg.min_stability)) begin
        n_bg = hcol;
        fg   = 1'b0;
      end
    end else if (d_prev < (PIX_W + 1)'(cfg.change_threshold)) begin
      n_stab = cnt_up(stab, cfg.max_stability);
      if (CMP_W'(n_stab) > CMP_W'(cfg.min_stability)) begin
        if (n_stab >= hstab) begin
          n_hcol  = pix;
          n_hstab = n_stab;
          n_bg    = pix;
          fg      = 1'b0;
        end else begin
          n_hstab = cnt_down(hstab);
        end
      end
    end else begin
      n_stab  = '0;
      n_hstab = cnt_down(hstab);
    end
  end

endmodule

// File: design/counting_background_subtractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_background_subtractor
// Per-pixel stability counting background subtractor for 8-bit grey video.
//
// in_ch carries one pixel (index, grey value, init flag) per transfer; out_ch
// returns one result per pixel in input order: the echoed index, a foreground
// flag and the pixel's stored background level. Settings are to be written
// over the APB-style port only while no pixel is in flight; the block itself
// does not enforce this. Pipeline: two address-fold stages, one state memory
// read, then the update registered into the output register.
// Throughput: one pixel per cycle; the state memory is read and written in
// the same cycle and a pixel following one at the same address takes the
// freshly written state from a forwarding register.
// When the receiver stalls, the whole pipeline holds and in_ch.ready drops
// while a result waits in the output register.
// Reset restores the default settings and empties the pipeline; memory
// contents are undefined, so every pixel must first arrive with init set.
// ----------------------------------------------------------------------------
module counting_background_subtractor #(
  parameter int PIXEL_COUNT = cbs_pkg::PIXEL_COUNT_DEF,
  parameter int COUNT_BITS  = cbs_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cbs_in_if.sink                         in_ch,
  cbs_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import cbs_pkg::*;

  localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int CB     = COUNT_BITS;
  localparam int DATA_W = 3 * PIX_W + 2 * CB;

  cfg_t              cfg;
  logic              en;
  pix_item_t         in_item;
  logic              b_v;
  pix_item_t         b_item;
  logic [ADDR_W-1:0] b_addr;

  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] cur;
  logic [DATA_W-1:0] wdata;
  logic              mem_we;

  logic              p3_v_r;
  pix_item_t         p3_item_r;
  logic [ADDR_W-1:0] p3_addr_r;
  logic              fwd_r;
  logic [DATA_W-1:0] fwd_data_r;

  logic              out_v_r;
  logic [IDX_W-1:0]  out_index_r;
  logic              out_fg_r;
  logic [PIX_W-1:0]  out_bg_r;

  logic [PIX_W-1:0]  c_prev;
  logic [CB-1:0]     c_stab;
  logic [PIX_W-1:0]  c_hcol;
  logic [CB-1:0]     c_hstab;
  logic [PIX_W-1:0]  c_bg;
  logic [CB-1:0]     n_stab;
  logic [PIX_W-1:0]  n_hcol;
  logic [CB-1:0]     n_hstab;
  logic [PIX_W-1:0]  n_bg;
  logic              n_fg;

  cbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_item     = '{pixel_index: in_ch.pixel_index,
                         pixel_value: in_ch.pixel_value,
                         init_frame:  in_ch.init_frame};

  cbs_addr_map #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .ADDR_W      (ADDR_W)
  ) u_addr_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_ch.valid),
    .in_item  (in_item),
    .out_v    (b_v),
    .out_item (b_item),
    .out_addr (b_addr)
  );

  assign mem_we = p3_v_r && en;

  cbs_state_mem #(
    .DEPTH  (PIXEL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_state_mem (
    .clk   (clk),
    .re    (en),
    .raddr (b_addr),
    .rdata (rd_data),
    .we    (mem_we),
    .waddr (p3_addr_r),
    .wdata (wdata)
  );

  // init overrides the stored entry, otherwise forwarded or memory state
  always_comb begin
    if (p3_item_r.init_frame) begin
      cur = {p3_item_r.pixel_value, CB'(0), p3_item_r.pixel_value, CB'(0), PIX_W'(0)};
    end else if (fwd_r) begin
      cur = fwd_data_r;
    end else begin
      cur = rd_data;
    end
  end

  assign {c_prev, c_stab, c_hcol, c_hstab, c_bg} = cur;

  cbs_update #(
    .CB (CB)
  ) u_update (
    .cfg     (cfg),
    .pix     (p3_item_r.pixel_value),
    .prev    (c_prev),
    .stab    (c_stab),
    .hcol    (c_hcol),
    .hstab   (c_hstab),
    .bg      (c_bg),
    .n_stab  (n_stab),
    .n_hcol  (n_hcol),
    .n_hstab (n_hstab),
    .n_bg    (n_bg),
    .fg      (n_fg)
  );

  assign wdata = {p3_item_r.pixel_value, n_stab, n_hcol, n_hstab, n_bg};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r  <= b_v;
      fwd_r   <= b_v && p3_v_r && (b_addr == p3_addr_r);
      out_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_item_r   <= b_item;
      p3_addr_r   <= b_addr;
      fwd_data_r  <= wdata;
      out_index_r <= p3_item_r.pixel_index;
      out_fg_r    <= n_fg;
      out_bg_r    <= n_bg;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.out_index        = out_index_r;
  assign out_ch.foreground       = out_fg_r;
  assign out_ch.background_value = out_bg_r;

  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> p3_v_r)
    else $error("forwarded state without an item in the update stage");

  a_write_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_v_r)
    else $error("state write-back without a result in the output register");

  a_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p3_v_r && !en) |=> (p3_v_r && $stable(p3_addr_r)))
    else $error("update stage changed while stalled");

endmodule

// File: test/cbs_mask_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_mask_checker
// Watches the pixel channel, the result channel and the register port. Keeps
// its own copy of the settings and of every touched pixel's state. Predicts
// the foreground flag and background level of each accepted pixel, and
// compares every result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cbs_mask_checker
  import cbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cbs_in_if                     pix_in,
  cbs_out_if                    pix_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    bg_seen
);

  localparam int COUNT_LIMIT = (1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] prev;
    logic [15:0]      stab;
    logic [PIX_W-1:0] hcol;
    logic [15:0]      hstab;
    logic [PIX_W-1:0] bg;
  } pixel_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             fg;
    logic [PIX_W-1:0] bg;
  } pixel_mask_t;

  pixel_state_t pixel_mem[int];
  pixel_mask_t  mask_backlog[$];

  logic hist_mode;
  int   min_stab;
  int   max_stab;
  int   change_thr;
  int   hist_thr;
  int   n_fail = 0;
  int   n_checked = 0;
  int   n_bg = 0;

  function automatic int gap8(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int raise_count(int c);
    return (c < max_stab && c < COUNT_LIMIT) ? c + 1 : c;
  endfunction

  function automatic pixel_mask_t step_pixel(pix_item_t px);
    int           addr;
    pixel_state_t st;
    int           stab;
    int           hstab;
    int           bumped;
    logic         fg;
    addr = int'(px.pixel_index) % PIXEL_COUNT_DEF;
    if (px.init_frame) begin
      st = '0;
      st.prev = px.pixel_value;
      st.hcol = px.pixel_value;
    end else if (pixel_mem.exists(addr)) begin
      st = pixel_mem[addr];
    end else begin
      st = '0;
    end
    stab = st.stab;
    hstab = st.hstab;
    fg = 1'b1;
    if (!hist_mode) begin
      if (gap8(px.pixel_value, st.prev) < 3 * change_thr) begin
        bumped = (stab < COUNT_LIMIT) ? stab + 1 : stab;
        if (bumped == min_stab) begin
          stab = bumped - 1;
          st.bg = st.prev;
          fg = 1'b0;
        end else begin
          stab = bumped;
        end
      end else begin
        stab = 0;
      end
    end else if (gap8(px.pixel_value, st.hcol) < hist_thr) begin
      stab = 0;
      hstab = raise_count(hstab);
      if (hstab > min_stab) begin
        st.bg = st.hcol;
        fg = 1'b0;
      end
    end else if (gap8(px.pixel_value, st.prev) < change_thr) begin
      stab = raise_count(stab);
      if (stab > min_stab) begin
        if (stab >= hstab) begin
          st.hcol = px.pixel_value;
          hstab = stab;
          st.bg = px.pixel_value;
          fg = 1'b0;
        end else begin
          hstab = (hstab > 0) ? hstab - 1 : 0;
        end
      end
    end else begin
      stab = 0;
      hstab = (hstab > 0) ? hstab - 1 : 0;
    end
    st.stab = stab[15:0];
    st.hstab = hstab[15:0];
    st.prev = px.pixel_value;
    pixel_mem[addr] = st;
    return '{index: px.pixel_index, fg: fg, bg: st.bg};
  endfunction

  always @(posedge clk) begin : monitor
    pixel_mask_t want;
    pixel_mask_t got;
    if (!rst_n) begin
      hist_mode = HISTORY_MODE_RST;
      min_stab = MIN_STAB_RST;
      max_stab = MAX_STAB_RST;
      change_thr = CHANGE_THR_RST;
      hist_thr = HIST_THR_RST;
      mask_backlog.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        got = '{index: pix_out.out_index, fg: pix_out.foreground,
                bg: pix_out.background_value};
        if (mask_backlog.size() == 0) begin
          $error("result transfer for pixel %0d with no pixel outstanding", got.index);
          n_fail++;
        end else begin
          want = mask_backlog.pop_front();
          n_checked++;
          if (!want.fg) n_bg++;
          if (got.index !== want.index) begin
            $error("out_index: expected %0d, got %0d", want.index, got.index);
            n_fail++;
          end
          if (got.fg !== want.fg) begin
            $error("foreground (pixel %0d): expected %0d, got %0d",
                   want.index, want.fg, got.fg);
            n_fail++;
          end
          if (got.bg !== want.bg) begin
            $error("background_value (pixel %0d): expected %0d, got %0d",
                   want.index, want.bg, got.bg);
            n_fail++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_HISTORY_MODE: hist_mode = pwdata[0];
          REG_MIN_STAB:     min_stab = pwdata[MIN_W-1:0];
          REG_MAX_STAB:     max_stab = pwdata[MAX_W-1:0];
          REG_CHANGE_THR:   change_thr = pwdata[CT_W-1:0];
          REG_HIST_THR:     hist_thr = pwdata[HT_W-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        mask_backlog.push_back(step_pixel('{pixel_index: pix_in.pixel_index,
                                            pixel_value: pix_in.pixel_value,
                                            init_frame: pix_in.init_frame}));
      end
    end
    pending <= mask_backlog.size();
    fail_count <= n_fail;
    checked <= n_checked;
    bg_seen <= n_bg;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the counting background subtractor with pixel streams and register
// settings. A short hand-built sequence walks through every update rule, then
// random frames revisit a pool of pixel addresses with steady scenes, scene
// changes and noise under several settings and flow-control patterns. A
// steady run on one pixel drives the stability counts to their saturation.
// ----------------------------------------------------------------------------
module testbench;
  import cbs_pkg::*;

  typedef struct {
    int mode;
    int min_s;
    int max_s;
    int ct;
    int ht;
  } setting_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  localparam int               POOL = 12;
  localparam int               PHASE_ITEMS = 100;
  localparam int               SOAK_FRAMES = 40;
  localparam logic [IDX_W-1:0] SOAK_ADDR = 19'h33333;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int checked;
  int bg_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cur_mode;
  int cur_ct;
  int settings_run = 0;

  logic [IDX_W-1:0] pool_addr[POOL];
  logic [PIX_W-1:0] scene[POOL];
  logic [PIX_W-1:0] alt_scene[POOL];
  bit               pool_live[POOL];
  int               last_slot = 0;

  cbs_in_if  pix_in ();
  cbs_out_if pix_out ();

  counting_background_subtractor uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_in),
    .out_ch  (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cbs_mask_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_in     (pix_in),
    .pix_out    (pix_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .bg_seen    (bg_seen)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    pix_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic cfg_write(reg_idx_t r, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(setting_t s);
    cfg_write(REG_HISTORY_MODE, s.mode);
    cfg_write(REG_MIN_STAB, s.min_s);
    cfg_write(REG_MAX_STAB, s.max_s);
    cfg_write(REG_CHANGE_THR, s.ct);
    cfg_write(REG_HIST_THR, s.ht);
    cur_mode = s.mode;
    cur_ct = s.ct;
    settings_run++;
  endtask

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 88;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = 88;
      end
      default: begin
        send_idle_pct = 17;
        stall_pct = 17;
      end
    endcase
  endtask

  // one transfer; valid stays high into the next item when there is no gap
  task automatic send_pixel(pix_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.pixel_index <= it.pixel_index;
    pix_in.pixel_value <= it.pixel_value;
    pix_in.init_frame <= it.init_frame;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // mostly steady scenes with jitter around the change threshold
  function automatic pix_item_t next_pixel();
    pix_item_t it;
    int        slot;
    int        roll;
    int        jit;
    int        v;
    logic [PIX_W-1:0] held;
    if ($urandom_range(99) < 4) begin
      it.pixel_index = IDX_W'($urandom_range(524287));
      it.pixel_value = PIX_W'($urandom_range(255));
      it.init_frame = 1'b1;
      return it;
    end
    slot = ($urandom_range(99) < 35) ? last_slot : $urandom_range(POOL - 1);
    last_slot = slot;
    roll = $urandom_range(99);
    if (roll < 5) begin
      alt_scene[slot] = scene[slot];
      scene[slot] = PIX_W'($urandom_range(255));
    end else if (roll < 9) begin
      held = scene[slot];
      scene[slot] = alt_scene[slot];
      alt_scene[slot] = held;
    end
    jit = cur_mode ? cur_ct / 2 : (3 * cur_ct) / 2;
    v = int'(scene[slot]) + int'($urandom_range(2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    if ($urandom_range(99) < 5) v = $urandom_range(255);
    it.pixel_index = pool_addr[slot];
    it.pixel_value = v[PIX_W-1:0];
    it.init_frame = !pool_live[slot] || ($urandom_range(99) < 3);
    pool_live[slot] = 1'b1;
    return it;
  endfunction

  initial begin : stimulus
    setting_t plan[10];
    int       k;
    pix_in.valid = 1'b0;
    pix_in.pixel_index = '0;
    pix_in.pixel_value = '0;
    pix_in.init_frame = 1'b0;
    pool_addr[0] = '0;
    pool_addr[1] = '1;
    pool_addr[2] = 19'h55555;
    pool_addr[3] = 19'h2AAAA;
    for (k = 0; k < POOL; k++) begin
      if (k > 3) pool_addr[k] = IDX_W'($urandom_range(524287));
      scene[k] = PIX_W'($urandom_range(255));
      alt_scene[k] = PIX_W'($urandom_range(255));
      pool_live[k] = 1'b0;
    end
    cur_mode = HISTORY_MODE_RST;
    cur_ct = CHANGE_THR_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // default settings
    send_pixel(pix_item_t'{19'h55555, 8'd0, 1'b1});
    send_pixel(pix_item_t'{19'h55555, 8'd0, 1'b0});
    send_pixel(pix_item_t'{19'h55555, 8'd255, 1'b0});
    drain();

    // history rule: match, saturation, new colour, count down, replace
    apply_settings(setting_t'{1, 1, 4, 10, 20});
    send_pixel(pix_item_t'{19'h00000, 8'd100, 1'b1});
    repeat (5) send_pixel(pix_item_t'{19'h00000, 8'd100, 1'b0});
    for (k = 200; k <= 204; k++) send_pixel(pix_item_t'{19'h00000, k[7:0], 1'b0});
    send_pixel(pix_item_t'{19'h7FFFF, 8'd255, 1'b1});
    send_pixel(pix_item_t'{19'h7FFFF, 8'd255, 1'b0});
    send_pixel(pix_item_t'{19'h7FFFF, 8'd0, 1'b0});
    send_pixel(pix_item_t'{19'h7FFFF, 8'd0, 1'b1});
    drain();

    // simple rule: count up, reach min stability, large change
    apply_settings(setting_t'{0, 3, 900, 10, 20});
    send_pixel(pix_item_t'{19'h2AAAA, 8'd128, 1'b1});
    send_pixel(pix_item_t'{19'h2AAAA, 8'd128, 1'b0});
    send_pixel(pix_item_t'{19'h2AAAA, 8'd140, 1'b0});
    send_pixel(pix_item_t'{19'h2AAAA, 8'd150, 1'b0});
    send_pixel(pix_item_t'{19'h2AAAA, 8'd255, 1'b0});
    drain();

    plan[0] = '{1, 3, 20, 6, 12};
    plan[1] = '{0, 4, 20, 4, 12};
    plan[2] = '{1, 1, 2, 85, 255};
    plan[3] = '{0, 1, 900, 0, 0};
    plan[4] = '{1, 5, 65535, 10, 0};
    plan[5] = '{1, 65534, 65535, 8, 30};
    plan[6] = '{0, 2, 50, 85, 30};
    plan[7] = '{1, 2, 8, 3, 6};
    for (k = 8; k < 10; k++) begin
      plan[k] = '{$urandom_range(1), $urandom_range(1, 8), $urandom_range(2, 40),
                  $urandom_range(30), $urandom_range(60)};
    end
    for (k = 0; k < 10; k++) begin
      apply_settings(plan[k]);
      set_idling(idling_t'(k % 4));
      repeat (PHASE_ITEMS) send_pixel(next_pixel());
      drain();
    end

    // steady pixel until both counts hit max stability
    set_idling(IDLE_NONE);
    apply_settings(setting_t'{1, 2, 20, 1, 0});
    send_pixel(pix_item_t'{SOAK_ADDR, 8'd77, 1'b1});
    repeat (SOAK_FRAMES) send_pixel(pix_item_t'{SOAK_ADDR, 8'd77, 1'b0});
    drain();
    apply_settings(setting_t'{0, 5, 65535, 1, 0});
    repeat (4) send_pixel(pix_item_t'{SOAK_ADDR, 8'd77, 1'b0});
    drain();
    apply_settings(setting_t'{1, 5, 65535, 1, 255});
    repeat (4) send_pixel(pix_item_t'{SOAK_ADDR, 8'd77, 1'b0});
    drain();

    $display("%0d pixel results compared under %0d register settings, %0d background",
             checked, settings_run, bg_seen);
    $display("includes a %0d-frame steady run on one pixel to count saturation",
             SOAK_FRAMES);
    if (fail_count == 0) begin
      $display("counting_background_subtractor: match");
    end else begin
      $display("counting_background_subtractor: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("counting_background_subtractor: mismatch");
    $finish;
  end

endmodule
